@@ rtl/core/gbn_pkg.sv @@
// ----------------------------------------------------------------------------
// gbn_pkg
// Shared types and constants of the go-back-N sender window control.
// ----------------------------------------------------------------------------
package gbn_pkg;

    localparam int WINDOW    = 5;
    localparam int SEQ_LIMIT = 128;

    localparam int CMD_W  = 2;
    localparam int SEQ_W  = 7;
    localparam int CNT_W  = 8;
    localparam int ACT_W  = 2;
    localparam int TLEN_W = 10;
    localparam int STAT_W = 4;
    localparam int IDX_W  = 1;

    localparam logic [TLEN_W-1:0] FIRST_TIMEOUT_RST = TLEN_W'(20);
    localparam logic [TLEN_W-1:0] RETRY_TIMEOUT_RST = TLEN_W'(100);

    typedef enum logic [CMD_W-1:0] {
        CMD_NEW   = 2'd0,
        CMD_ACK   = 2'd1,
        CMD_TIMER = 2'd2,
        CMD_NONE  = 2'd3
    } t_cmd;

    typedef enum logic [ACT_W-1:0] {
        TMR_LEAVE = 2'd0,
        TMR_START = 2'd1,
        TMR_STOP  = 2'd2
    } t_timer_act;

    typedef enum logic [STAT_W-1:0] {
        ST_SENT        = 4'd0,
        ST_STORED      = 4'd1,
        ST_DROPPED     = 4'd2,
        ST_ACK_TAKEN   = 4'd3,
        ST_CORRUPT     = 4'd4,
        ST_NOT_ACK     = 4'd5,
        ST_DUPLICATE   = 4'd6,
        ST_OUT_OF_RNG  = 4'd7,
        ST_RETRANSMIT  = 4'd8
    } t_status;

    typedef enum logic [IDX_W-1:0] {
        REG_FIRST_TIMEOUT = 1'b0,
        REG_RETRY_TIMEOUT = 1'b1
    } t_reg_idx;

    typedef enum logic {
        S_IDLE = 1'b0,
        S_EMIT = 1'b1
    } t_state;

    // controller to datapath
    typedef struct packed {
        logic load;     // capture the accepted transaction
        logic step;     // produce one result into the output register
    } t_ctl_cmd;

    // datapath to controller
    typedef struct packed {
        logic cmd_none; // command on the input carries no work
        logic out_free; // output register can take a result this cycle
        logic last;     // the result produced now ends the run
    } t_dp_stat;

endpackage

@@ rtl/core/gbn_req_if.sv @@
// ----------------------------------------------------------------------------
// gbn_req_if
// Input channel: one event (new message, acknowledgement, timer expiry).
// ----------------------------------------------------------------------------
interface gbn_req_if;
    logic                        valid;
    logic                        ready;
    logic [gbn_pkg::CMD_W-1:0]   command;
    logic [gbn_pkg::SEQ_W-1:0]   ack_seq;
    logic                        ack_checksum_ok;
    logic                        ack_flag;

    modport source (output valid, command, ack_seq, ack_checksum_ok, ack_flag,
                    input ready);
    modport sink   (input valid, command, ack_seq, ack_checksum_ok, ack_flag,
                    output ready);
endinterface

@@ rtl/core/gbn_rsp_if.sv @@
// ----------------------------------------------------------------------------
// gbn_rsp_if
// Output channel: one result (transmit request, timer action, status).
// ----------------------------------------------------------------------------
interface gbn_rsp_if;
    logic                        valid;
    logic                        ready;
    logic                        transmit;
    logic [gbn_pkg::SEQ_W-1:0]   send_seq;
    logic [gbn_pkg::ACT_W-1:0]   timer_action;
    logic [gbn_pkg::TLEN_W-1:0]  timer_length;
    logic [gbn_pkg::STAT_W-1:0]  status;
    logic                        last;

    modport source (output valid, transmit, send_seq, timer_action, timer_length,
                    status, last, input ready);
    modport sink   (input valid, transmit, send_seq, timer_action, timer_length,
                    status, last, output ready);
endinterface

@@ rtl/core/gbn_ctrl.sv @@
// ----------------------------------------------------------------------------
// gbn_ctrl
// Sequencer: accepts one transaction, then steps the datapath once per
// result until the last one of the run is in the output register.
// ----------------------------------------------------------------------------
module gbn_ctrl (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_in_valid,
    input  gbn_pkg::t_dp_stat i_stat,
    output logic              o_in_ready,
    output gbn_pkg::t_ctl_cmd o_ctl
);

    gbn_pkg::t_state r_state;
    gbn_pkg::t_state n_state;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= gbn_pkg::S_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    always_comb begin
        n_state    = r_state;
        o_in_ready = 1'b0;
        o_ctl      = '0;
        case (r_state)
            gbn_pkg::S_IDLE: begin
                o_in_ready = 1'b1;
                o_ctl.load = i_in_valid;
                if (i_in_valid && !i_stat.cmd_none) begin
                    n_state = gbn_pkg::S_EMIT;
                end
            end
            gbn_pkg::S_EMIT: begin
                o_ctl.step = i_stat.out_free;
                if (i_stat.out_free && i_stat.last) begin
                    n_state = gbn_pkg::S_IDLE;
                end
            end
            default: begin
                n_state = gbn_pkg::S_IDLE;
            end
        endcase
    end

endmodule

@@ rtl/core/gbn_datapath.sv @@
// ----------------------------------------------------------------------------
// gbn_datapath
// Window state, timeout registers, captured transaction, run counters and
// the output register.
// ----------------------------------------------------------------------------
module gbn_datapath (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  gbn_pkg::t_ctl_cmd             i_ctl,
    output gbn_pkg::t_dp_stat             o_stat,
    input  logic                          i_cfg_we,
    input  logic [gbn_pkg::IDX_W-1:0]     i_cfg_idx,
    input  logic [gbn_pkg::TLEN_W-1:0]    i_cfg_wdata,
    input  logic [gbn_pkg::CMD_W-1:0]     i_command,
    input  logic [gbn_pkg::SEQ_W-1:0]     i_ack_seq,
    input  logic                          i_ack_checksum_ok,
    input  logic                          i_ack_flag,
    input  logic                          i_out_ready,
    output logic                          o_out_valid,
    output logic                          o_transmit,
    output logic [gbn_pkg::SEQ_W-1:0]     o_send_seq,
    output logic [gbn_pkg::ACT_W-1:0]     o_timer_action,
    output logic [gbn_pkg::TLEN_W-1:0]    o_timer_length,
    output logic [gbn_pkg::STAT_W-1:0]    o_status,
    output logic                          o_last
);

    localparam logic [gbn_pkg::CNT_W-1:0] WIN_C = gbn_pkg::CNT_W'(gbn_pkg::WINDOW);
    localparam logic [gbn_pkg::CNT_W-1:0] LIM_C = gbn_pkg::CNT_W'(gbn_pkg::SEQ_LIMIT);
    localparam logic [gbn_pkg::CNT_W-1:0] ONE_C = gbn_pkg::CNT_W'(1);

    logic [gbn_pkg::TLEN_W-1:0] r_first_to, r_retry_to;
    logic [gbn_pkg::CNT_W-1:0]  r_base, r_nts, r_stored, r_cur, r_end;
    logic [gbn_pkg::CNT_W-1:0]  n_base, n_nts, n_stored, n_cur, n_end;
    gbn_pkg::t_cmd              r_cmd;
    logic [gbn_pkg::SEQ_W-1:0]  r_seq;
    logic                       r_ok, r_flag, r_first;

    logic                       r_o_valid;
    logic                       r_o_tx, r_o_last;
    logic [gbn_pkg::SEQ_W-1:0]  r_o_seq;
    gbn_pkg::t_timer_act        r_o_act;
    logic [gbn_pkg::TLEN_W-1:0] r_o_len;
    gbn_pkg::t_status           r_o_stat;

    logic                       n_o_tx, n_o_last;
    logic [gbn_pkg::CNT_W-1:0]  n_o_seq;
    gbn_pkg::t_timer_act        n_o_act;
    logic [gbn_pkg::TLEN_W-1:0] n_o_len;
    gbn_pkg::t_status           n_o_stat;

    logic [gbn_pkg::CNT_W-1:0]  ack_w, new_base, lim, fin;

    assign o_stat.cmd_none = (gbn_pkg::t_cmd'(i_command) == gbn_pkg::CMD_NONE);
    assign o_stat.out_free = !r_o_valid || i_out_ready;
    assign o_stat.last     = n_o_last;

    assign ack_w    = {1'b0, r_seq};
    assign new_base = ack_w + ONE_C;
    assign lim      = new_base + WIN_C;
    assign fin      = (lim < r_stored) ? lim : r_stored;

    always_comb begin
        n_base   = r_base;
        n_nts    = r_nts;
        n_stored = r_stored;
        n_cur    = r_cur;
        n_end    = r_end;
        n_o_tx   = 1'b0;
        n_o_seq  = '0;
        n_o_act  = gbn_pkg::TMR_LEAVE;
        n_o_len  = '0;
        n_o_stat = gbn_pkg::ST_SENT;
        n_o_last = 1'b1;
        if (r_first) begin
            case (r_cmd)
                gbn_pkg::CMD_NEW: begin
                    if (r_stored >= LIM_C) begin
                        n_o_stat = gbn_pkg::ST_DROPPED;
                    end else begin
                        n_stored = r_stored + ONE_C;
                        if (r_nts < r_base + WIN_C) begin
                            n_o_tx  = 1'b1;
                            n_o_seq = r_nts;
                            n_nts   = r_nts + ONE_C;
                            if (r_base == r_nts) begin
                                n_o_act = gbn_pkg::TMR_START;
                                n_o_len = r_first_to;
                            end
                        end else begin
                            n_o_stat = gbn_pkg::ST_STORED;
                        end
                    end
                end
                gbn_pkg::CMD_ACK: begin
                    if (!r_ok) begin
                        n_o_stat = gbn_pkg::ST_CORRUPT;
                    end else if (!r_flag) begin
                        n_o_stat = gbn_pkg::ST_NOT_ACK;
                    end else if (ack_w < r_base) begin
                        n_o_stat = gbn_pkg::ST_DUPLICATE;
                    end else if (ack_w >= r_nts) begin
                        n_o_stat = gbn_pkg::ST_OUT_OF_RNG;
                    end else begin
                        // slide the window, then drain buffered packets it lets out
                        n_base   = new_base;
                        n_nts    = fin;
                        n_cur    = r_nts;
                        n_end    = fin;
                        n_o_stat = gbn_pkg::ST_ACK_TAKEN;
                        n_o_last = (fin == r_nts);
                        if (fin == new_base) begin
                            n_o_act = gbn_pkg::TMR_STOP;
                        end else if (new_base == r_nts) begin
                            n_o_act = gbn_pkg::TMR_START;
                            n_o_len = r_first_to;
                        end else begin
                            n_o_act = gbn_pkg::TMR_START;
                            n_o_len = r_retry_to;
                        end
                    end
                end
                gbn_pkg::CMD_TIMER: begin
                    n_o_stat = gbn_pkg::ST_RETRANSMIT;
                    n_o_act  = gbn_pkg::TMR_START;
                    n_o_len  = r_retry_to;
                    if (r_base < r_nts) begin
                        n_o_tx   = 1'b1;
                        n_o_seq  = r_base;
                        n_cur    = r_base + ONE_C;
                        n_end    = r_nts;
                        n_o_last = (r_base + ONE_C == r_nts);
                    end
                end
                default: begin
                    n_o_last = 1'b1;
                end
            endcase
        end else begin
            // rest of a run: one outstanding slot per result
            n_o_tx   = 1'b1;
            n_o_seq  = r_cur;
            n_o_stat = (r_cmd == gbn_pkg::CMD_TIMER) ? gbn_pkg::ST_RETRANSMIT
                                                     : gbn_pkg::ST_SENT;
            n_cur    = r_cur + ONE_C;
            n_o_last = (r_cur + ONE_C == r_end);
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_first_to <= gbn_pkg::FIRST_TIMEOUT_RST;
            r_retry_to <= gbn_pkg::RETRY_TIMEOUT_RST;
            r_base     <= '0;
            r_nts      <= '0;
            r_stored   <= '0;
            r_first    <= 1'b0;
            r_o_valid  <= 1'b0;
        end else begin
            if (i_cfg_we) begin
                case (gbn_pkg::t_reg_idx'(i_cfg_idx))
                    gbn_pkg::REG_FIRST_TIMEOUT: r_first_to <= i_cfg_wdata;
                    gbn_pkg::REG_RETRY_TIMEOUT: r_retry_to <= i_cfg_wdata;
                    default: begin
                    end
                endcase
            end
            if (i_ctl.load) begin
                r_first <= 1'b1;
            end else if (i_ctl.step) begin
                r_first <= 1'b0;
            end
            if (i_ctl.step) begin
                r_base    <= n_base;
                r_nts     <= n_nts;
                r_stored  <= n_stored;
                r_o_valid <= 1'b1;
            end else if (i_out_ready) begin
                r_o_valid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_ctl.load) begin
            r_cmd  <= gbn_pkg::t_cmd'(i_command);
            r_seq  <= i_ack_seq;
            r_ok   <= i_ack_checksum_ok;
            r_flag <= i_ack_flag;
        end
        if (i_ctl.step) begin
            r_cur    <= n_cur;
            r_end    <= n_end;
            r_o_tx   <= n_o_tx;
            r_o_seq  <= n_o_seq[gbn_pkg::SEQ_W-1:0];
            r_o_act  <= n_o_act;
            r_o_len  <= n_o_len;
            r_o_stat <= n_o_stat;
            r_o_last <= n_o_last;
        end
    end

    assign o_out_valid    = r_o_valid;
    assign o_transmit     = r_o_tx;
    assign o_send_seq     = r_o_seq;
    assign o_timer_action = r_o_act;
    assign o_timer_length = r_o_len;
    assign o_status       = r_o_stat;
    assign o_last         = r_o_last;

endmodule

@@ rtl/core/go_back_n_sender_window.sv @@
// ----------------------------------------------------------------------------
// go_back_n_sender_window
// Window control of a go-back-N sender: tracks window base, next slot to
// send and stored count, and tells which slots to transmit and how to drive
// the retransmit timer.
// ----------------------------------------------------------------------------
// Usage:
//   i_req carries one event per transaction: new message, acknowledgement
//   or timer expiry. o_rsp returns one to WINDOW+1 results per event, the
//   final one marked by last; the no-work command CMD_NONE returns nothing.
//   Timing: the sequencer takes the event, then writes one result per
//   cycle into the output register while that register is free; the next
//   event is taken right after the last result is loaded, even while
//   that result waits.
//   A stall on o_rsp holds the output register and the sequencer with it;
//   nothing is lost.
//   The user writes the timeout registers through i_cfg_* only while idle;
//   the block does not check this. Index 0: first_timeout, 1: retry_timeout.
//   Reset (synchronous, low) empties the window and restores the default
//   timeouts; no clearing pass is needed.
// ----------------------------------------------------------------------------
module go_back_n_sender_window (
    input  logic                       i_clk,
    input  logic                       i_rst_n,
    input  logic                       i_cfg_we,
    input  logic [gbn_pkg::IDX_W-1:0]  i_cfg_idx,
    input  logic [gbn_pkg::TLEN_W-1:0] i_cfg_wdata,
    gbn_req_if.sink                    i_req,
    gbn_rsp_if.source                  o_rsp
);

    gbn_pkg::t_ctl_cmd ctl;
    gbn_pkg::t_dp_stat stat;
    logic              in_ready;

    assign i_req.ready = in_ready;

    gbn_ctrl u_ctrl (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_in_valid (i_req.valid),
        .i_stat     (stat),
        .o_in_ready (in_ready),
        .o_ctl      (ctl)
    );

    gbn_datapath u_datapath (
        .i_clk             (i_clk),
        .i_rst_n           (i_rst_n),
        .i_ctl             (ctl),
        .o_stat            (stat),
        .i_cfg_we          (i_cfg_we),
        .i_cfg_idx         (i_cfg_idx),
        .i_cfg_wdata       (i_cfg_wdata),
        .i_command         (i_req.command),
        .i_ack_seq         (i_req.ack_seq),
        .i_ack_checksum_ok (i_req.ack_checksum_ok),
        .i_ack_flag        (i_req.ack_flag),
        .i_out_ready       (o_rsp.ready),
        .o_out_valid       (o_rsp.valid),
        .o_transmit        (o_rsp.transmit),
        .o_send_seq        (o_rsp.send_seq),
        .o_timer_action    (o_rsp.timer_action),
        .o_timer_length    (o_rsp.timer_length),
        .o_status          (o_rsp.status),
        .o_last            (o_rsp.last)
    );

endmodule
